### hdl/mac_pair_flow_byte_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the MAC-pair flow byte table
// Shared helpers so every check in the block reads the same way.
// ---------------------------------------------------------------------------
`ifndef MAC_PAIR_FLOW_BYTE_TABLE_ASSERT_SVH
`define MAC_PAIR_FLOW_BYTE_TABLE_ASSERT_SVH

// Same-cycle implication, quiet while reset is high
`define MPFBT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpfbt check failed");

// Next-cycle implication, quiet while reset is high
`define MPFBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpfbt check failed");

`endif

### hdl/mpfbt_pkg.sv
// ---------------------------------------------------------------------------
// mpfbt_pkg
// Types, codes and sizes shared by the MAC-pair flow byte table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpfbt_pkg;

   // Default table depth
   localparam int TABLE_ENTRIES_DEF = 32;

   // Field widths
   localparam int MAC_W   = 48;
   localparam int TOTAL_W = 64;
   localparam int BYTES_W = 32;
   localparam int COUNT_W = 6;

   typedef logic [MAC_W-1:0]   mac_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Request kinds
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_ACCUM     = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_DROPPED   = 3'd2;
   localparam logic [2:0] ST_DELIVERED = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   // IP version that counts as IPv4
   localparam logic [3:0] IP_V4 = 4'd4;

   typedef struct packed {
      logic [1:0]         kind;
      mac_type            src_mac;
      mac_type            dst_mac;
      logic [3:0]         ip_version;
      logic [BYTES_W-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      mac_type    out_src_mac;
      mac_type    out_dst_mac;
      total_type  ipv4_bytes;
      total_type  ipv6_bytes;
      count_type  entry_count;
      logic       last;
   } rsp_type;

   // One flow entry as stored in the table memory
   typedef struct packed {
      mac_type   src;
      mac_type   dst;
      total_type v4_total;
      total_type v6_total;
   } entry_type;

endpackage

`default_nettype wire

### hdl/mpfbt_store.sv
// ---------------------------------------------------------------------------
// mpfbt_store
// Flow entry memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpfbt_store #(
   parameter int ENTRIES = mpfbt_pkg::TABLE_ENTRIES_DEF,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire                       clock,
   input  wire                       rd_en,
   input  wire [IDX_W-1:0]           rd_addr,
   output mpfbt_pkg::entry_type      rd_data,
   input  wire                       wr_en,
   input  wire [IDX_W-1:0]           wr_addr,
   input  mpfbt_pkg::entry_type      wr_data
);

   mpfbt_pkg::entry_type mem [ENTRIES];
   mpfbt_pkg::entry_type rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the data while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/mac_pair_flow_byte_table.sv
// A request is taken when start is high and busy is low. Results leave on rsp_data for exactly
// one cycle each, marked by rsp_strobe; the receiver cannot stall them, so it must take every
// strobe. An add compares one stored key per cycle through the single read port of the entry
// memory: on a miss the last compare also writes the new entry and the result (or, with the
// table full, a dropped result), and on a match a further step writes the updated total back
// with the result. A remove delivers the last stored entry; a flush of n entries gives its n
// results on consecutive cycles with last on the final one. A request that finds the table
// empty, and an add into an empty table, are answered from the idle state with no read.
// Kind 3 is taken and gives no result.
// ---------------------------------------------------------------------------
// mac_pair_flow_byte_table
// Bounded flow table keyed by source/destination MAC with IPv4/IPv6 byte totals.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mac_pair_flow_byte_table #(
   parameter int TABLE_ENTRIES = mpfbt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  mpfbt_pkg::req_type   req_data,
   output logic                 rsp_strobe,
   output mpfbt_pkg::rsp_type   rsp_data
);

`include "mac_pair_flow_byte_table_assert.svh"

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SEARCH = 5'b00010,
      S_ACCUM  = 5'b00100,
      S_POP    = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   mpfbt_pkg::req_type   req_ff, req_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   mpfbt_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   mpfbt_pkg::entry_type rd_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   mpfbt_pkg::entry_type wr_data;

   logic [CNT_W-1:0]     scan_next;
   logic [CNT_W-1:0]     cnt_dec;
   logic                 at_end;
   logic                 hit;

   // Build a fresh entry from a request
   function automatic mpfbt_pkg::entry_type new_entry(input mpfbt_pkg::req_type r);
      mpfbt_pkg::entry_type e;
      e.src      = r.src_mac;
      e.dst      = r.dst_mac;
      e.v4_total = (r.ip_version == mpfbt_pkg::IP_V4) ?
                   mpfbt_pkg::total_type'(r.byte_count) : '0;
      e.v6_total = (r.ip_version == mpfbt_pkg::IP_V4) ?
                   '0 : mpfbt_pkg::total_type'(r.byte_count);
      return e;
   endfunction

   // Result without entry fields
   function automatic mpfbt_pkg::rsp_type short_rsp(input logic [2:0] status,
                                                     input logic [CNT_W-1:0] count);
      mpfbt_pkg::rsp_type r;
      r             = '0;
      r.status      = status;
      r.entry_count = mpfbt_pkg::count_type'(count);
      r.last        = 1'b1;
      return r;
   endfunction

   // Result carrying a stored entry
   function automatic mpfbt_pkg::rsp_type entry_rsp(input mpfbt_pkg::entry_type e,
                                                     input logic [CNT_W-1:0] count,
                                                     input logic last);
      mpfbt_pkg::rsp_type r;
      r.status      = mpfbt_pkg::ST_DELIVERED;
      r.out_src_mac = e.src;
      r.out_dst_mac = e.dst;
      r.ipv4_bytes  = e.v4_total;
      r.ipv6_bytes  = e.v6_total;
      r.entry_count = mpfbt_pkg::count_type'(count);
      r.last        = last;
      return r;
   endfunction

   mpfbt_store #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Scan bookkeeping: entry under compare is scan_ff
   assign scan_next = CNT_W'(scan_ff) + CNT_W'(1);
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign at_end    = (scan_next == cnt_ff);
   assign hit       = (rd_data.src == req_ff.src_mac) && (rd_data.dst == req_ff.dst_mac);

   // Sequence one request: read, compare, modify, write back; or pop, or flush
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = scan_next[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = scan_ff;
      wr_data       = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in  = req_data;
               scan_in = '0;
               case (req_data.kind)
                  mpfbt_pkg::KIND_ADD: begin
                     if (cnt_ff == '0) begin
                        // empty table: insert at once
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data       = new_entry(req_data);
                        cnt_in        = CNT_W'(1);
                        rsp_in        = short_rsp(mpfbt_pkg::ST_INSERTED, CNT_W'(1));
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  mpfbt_pkg::KIND_REMOVE: begin
                     if (cnt_ff == '0) begin
                        rsp_in        = short_rsp(mpfbt_pkg::ST_EMPTY, '0);
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_dec[IDX_W-1:0];
                        cnt_in   = cnt_dec;
                        state_in = S_POP;
                     end
                  end
                  mpfbt_pkg::KIND_FLUSH: begin
                     if (cnt_ff == '0) begin
                        rsp_in        = short_rsp(mpfbt_pkg::ST_EMPTY, '0);
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_FLUSH;
                     end
                  end
                  default: begin
                     // unused kind: drop silently
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (hit) begin
               // hold the read data for the update
               state_in = S_ACCUM;
            end else if (at_end) begin
               if (cnt_ff < CNT_W'(TABLE_ENTRIES)) begin
                  wr_en         = 1'b1;
                  wr_addr       = cnt_ff[IDX_W-1:0];
                  wr_data       = new_entry(req_ff);
                  cnt_in        = cnt_ff + CNT_W'(1);
                  rsp_in        = short_rsp(mpfbt_pkg::ST_INSERTED, cnt_ff + CNT_W'(1));
               end else begin
                  rsp_in        = short_rsp(mpfbt_pkg::ST_DROPPED, cnt_ff);
               end
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               scan_in = scan_next[IDX_W-1:0];
            end
         end

         S_ACCUM: begin
            // add to the selected total and write back
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            wr_data = rd_data;
            if (req_ff.ip_version == mpfbt_pkg::IP_V4) begin
               wr_data.v4_total = rd_data.v4_total +
                                  mpfbt_pkg::total_type'(req_ff.byte_count);
            end else begin
               wr_data.v6_total = rd_data.v6_total +
                                  mpfbt_pkg::total_type'(req_ff.byte_count);
            end
            rsp_in        = short_rsp(mpfbt_pkg::ST_ACCUM, cnt_ff);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         S_POP: begin
            rsp_in        = entry_rsp(rd_data, cnt_ff, 1'b1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         S_FLUSH: begin
            rsp_in        = entry_rsp(rd_data, '0, at_end);
            rsp_strobe_in = 1'b1;
            if (at_end) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               scan_in = scan_next[IDX_W-1:0];
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         scan_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         scan_ff       <= scan_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Hold request and result payload
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   `MPFBT_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(TABLE_ENTRIES))
   `MPFBT_ASSERT_SAME(a_no_rw_clash, clock, reset, wr_en && rd_en, wr_addr != rd_addr)
   `MPFBT_ASSERT_NEXT(a_flush_run, clock, reset, rsp_strobe && !rsp_data.last, rsp_strobe)
   `MPFBT_ASSERT_NEXT(a_flush_clears, clock, reset, (state_ff == S_FLUSH) && at_end,
                      (cnt_ff == '0) && (state_ff == S_IDLE))
   `MPFBT_ASSERT_SAME(a_empty_count, clock, reset,
                      rsp_strobe && (rsp_data.status == mpfbt_pkg::ST_EMPTY),
                      rsp_data.entry_count == '0)

endmodule

`default_nettype wire
